// ===== hw/rtl/poi_pkg.sv =====
package poi_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam int VEL_W  = 32;
  localparam int GAIN_W = 18;
  localparam int DT_W   = 20;
  localparam int POS_W  = 48;
  localparam int HDG_W  = 32;
  localparam int CFG_IDX_W = 2;

  // shared multiplier operand and product widths
  localparam int MA_W = 35;
  localparam int MB_W = 31;
  localparam int MP_W = MA_W + MB_W;

  // cordic vector and angle widths
  localparam int X_W = 52;
  localparam int Z_W = 34;
  localparam int T_W = 60;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd65536;
  localparam logic [29:0]       INV_GAIN   = 30'd652032874;
  localparam logic [21:0]       TURN_K     = 22'd2670177;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_X        = 2'd0,
    CFG_GAIN_Y        = 2'd1,
    CFG_GAIN_TURN_POS = 2'd2,
    CFG_GAIN_TURN_NEG = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_SX, MUL_SY, MUL_SZ, MUL_CX, MUL_CY, MUL_TK, MUL_TL, MUL_TH, MUL_WX, MUL_WY
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_SX, WB_SY, WB_SZ, WB_X, WB_Y, WB_T, WB_HL, WB_HH, WB_DX, WB_DY
  } wb_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     load_in;
    logic     cordic_en;
    logic     out_load;
  } poi_cmd_t;

  // arctangent of 2^-i as binary angle, full turn = 2^32
  function automatic logic [29:0] poi_atan(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      5'd30: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/poi_ctrl.sv =====
module poi_ctrl
  import poi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ITER_W = $clog2(CORDIC_STEPS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output poi_cmd_t          cmd,
  output logic [ITER_W-1:0] iter
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MSX, ST_MSY, ST_MSZ, ST_MCX, ST_MCY, ST_MTK, ST_MTL, ST_MTH,
    ST_CORD, ST_MWX, ST_MWY, ST_WDY, ST_LOAD
  } state_t;

  state_t            state_r;
  logic [ITER_W-1:0] iter_r;
  logic              out_valid_r;
  logic              iter_last;
  logic              slot_free;

  assign iter_last = (iter_r == ITER_W'(CORDIC_STEPS - 1));
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign iter      = iter_r;

  always_comb begin
    cmd = '{mul_sel: MUL_SX, wb_sel: WB_NONE, load_in: 1'b0, cordic_en: 1'b0,
            out_load: 1'b0};
    unique case (state_r)
      ST_IDLE: cmd.load_in = in_valid;
      ST_MSX:  cmd.mul_sel = MUL_SX;
      ST_MSY:  begin cmd.mul_sel = MUL_SY; cmd.wb_sel = WB_SX; end
      ST_MSZ:  begin cmd.mul_sel = MUL_SZ; cmd.wb_sel = WB_SY; end
      ST_MCX:  begin cmd.mul_sel = MUL_CX; cmd.wb_sel = WB_SZ; end
      ST_MCY:  begin cmd.mul_sel = MUL_TK; cmd.wb_sel = WB_X;  end
      ST_MTK:  begin cmd.mul_sel = MUL_CY; cmd.wb_sel = WB_T;  end
      ST_MTL:  begin cmd.mul_sel = MUL_TL; cmd.wb_sel = WB_Y;  end
      ST_MTH:  begin cmd.mul_sel = MUL_TH; cmd.wb_sel = WB_HL; end
      ST_CORD: begin
        cmd.cordic_en = 1'b1;
        // high heading partial product lands on the first rotation
        if (iter_r == '0) begin
          cmd.wb_sel = WB_HH;
        end
      end
      ST_MWX:  cmd.mul_sel = MUL_WX;
      ST_MWY:  begin cmd.mul_sel = MUL_WY; cmd.wb_sel = WB_DX; end
      ST_WDY:  cmd.wb_sel = WB_DY;
      ST_LOAD: cmd.out_load = slot_free;
      default: cmd.load_in = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace the one taken at the same edge
      if (state_r == ST_LOAD && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          state_r <= ST_MSX;
        end
        ST_MSX: state_r <= ST_MSY;
        ST_MSY: state_r <= ST_MSZ;
        ST_MSZ: state_r <= ST_MCX;
        ST_MCX: state_r <= ST_MCY;
        ST_MCY: state_r <= ST_MTK;
        ST_MTK: state_r <= ST_MTL;
        ST_MTL: state_r <= ST_MTH;
        ST_MTH: begin
          state_r <= ST_CORD;
          iter_r  <= '0;
        end
        ST_CORD: begin
          iter_r <= iter_r + 1'b1;
          if (iter_last) begin
            state_r <= ST_MWX;
          end
        end
        ST_MWX: state_r <= ST_MWY;
        ST_MWY: state_r <= ST_WDY;
        ST_WDY: state_r <= ST_LOAD;
        ST_LOAD: if (slot_free) begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/poi_dp.sv =====
module poi_dp
  import poi_pkg::*;
#(
  parameter int ITER_W = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  poi_cmd_t                cmd,
  input  logic [ITER_W-1:0]       iter,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [GAIN_W-1:0]       cfg_wdata,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  logic signed [VEL_W-1:0] in_turn_rate,
  input  logic [DT_W-1:0]         in_time_step,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [HDG_W-1:0] out_heading,
  output logic signed [VEL_W-1:0] out_scaled_vel_x,
  output logic signed [VEL_W-1:0] out_scaled_vel_y,
  output logic signed [VEL_W-1:0] out_scaled_turn_rate,
  output logic                    out_stationary
);

  localparam logic signed [MP_W-1:0] VEL_MAX = MP_W'(64'sh7FFF_FFFF);
  localparam logic signed [MP_W-1:0] VEL_MIN = -MP_W'(64'sh8000_0000);
  localparam logic signed [POS_W+1:0] POS_MAX = (POS_W+2)'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [POS_W+1:0] POS_MIN = -(POS_W+2)'(64'sh8000_0000_0000);

  logic [GAIN_W-1:0] gain_x_r, gain_y_r, gain_tp_r, gain_tn_r;
  logic signed [VEL_W-1:0] vx_r, vy_r, vz_r;
  logic [DT_W-1:0]         dt_r;
  logic signed [VEL_W-1:0] sx_r, sy_r, sz_r;
  logic signed [MP_W-1:0]  p_r;
  logic signed [X_W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0]   z_r;
  logic                    neg_r;
  logic [T_W-1:0]          t_r, h_r;
  logic signed [POS_W-1:0] acc_x_r, acc_y_r;
  logic [HDG_W-1:0]        acc_h_r;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  prod;
  logic signed [MP_W-1:0]  rnd16, rnd14, rnd20;
  logic signed [VEL_W-1:0] sat_vel;
  logic signed [X_W-1:0]   xr, xs, ys, wx_full, wy_full;
  logic signed [MA_W-1:0]  wx, wy;
  logic signed [Z_W-1:0]   atan_s;
  logic signed [HDG_W-1:0] z_init;
  logic signed [POS_W+1:0] sum_pos;
  logic signed [POS_W-1:0] sat_pos;

  function automatic logic in_ready_quad(input logic [HDG_W-1:0] h);
    return h[HDG_W-1] ^ h[HDG_W-2];
  endfunction

  // shared multiplier, product registered
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SX: begin mul_a = MA_W'(vx_r); mul_b = MB_W'(gain_x_r); end
      MUL_SY: begin mul_a = MA_W'(vy_r); mul_b = MB_W'(gain_y_r); end
      MUL_SZ: begin
        mul_a = MA_W'(vz_r);
        mul_b = vz_r[VEL_W-1] ? MB_W'(gain_tn_r) : MB_W'(gain_tp_r);
      end
      MUL_CX: begin mul_a = MA_W'(sx_r); mul_b = MB_W'(INV_GAIN); end
      MUL_CY: begin mul_a = MA_W'(sy_r); mul_b = MB_W'(INV_GAIN); end
      MUL_TK: begin mul_a = MA_W'(sz_r); mul_b = MB_W'(TURN_K); end
      MUL_TL: begin mul_a = MA_W'(t_r[29:0]); mul_b = MB_W'(dt_r); end
      MUL_TH: begin mul_a = MA_W'(t_r[T_W-1:30]); mul_b = MB_W'(dt_r); end
      MUL_WX: begin mul_a = wx; mul_b = MB_W'(dt_r); end
      MUL_WY: begin mul_a = wy; mul_b = MB_W'(dt_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // rounding taps on the product
  assign rnd16 = (p_r + (MP_W'(1) <<< 15)) >>> 16;
  assign rnd14 = (p_r + (MP_W'(1) <<< 13)) >>> 14;
  assign rnd20 = (p_r + (MP_W'(1) <<< 19)) >>> 20;

  always_comb begin
    if (rnd16 > VEL_MAX) begin
      sat_vel = VEL_MAX[VEL_W-1:0];
    end else if (rnd16 < VEL_MIN) begin
      sat_vel = VEL_MIN[VEL_W-1:0];
    end else begin
      sat_vel = rnd16[VEL_W-1:0];
    end
  end

  // second or third quadrant: negate vector, turn angle by half
  assign xr = neg_r ? -rnd14[X_W-1:0] : rnd14[X_W-1:0];

  assign xs     = x_r >>> iter;
  assign ys     = y_r >>> iter;
  assign atan_s = Z_W'(poi_atan(5'(iter)));

  assign wx_full = (x_r + (X_W'(1) <<< 15)) >>> 16;
  assign wy_full = (y_r + (X_W'(1) <<< 15)) >>> 16;
  assign wx      = wx_full[MA_W-1:0];
  assign wy      = wy_full[MA_W-1:0];

  assign z_init = (in_ready_quad(acc_h_r)) ? HDG_W'(acc_h_r + 32'h8000_0000)
                                            : HDG_W'(acc_h_r);

  always_comb begin
    if (cmd.wb_sel == WB_DX) begin
      sum_pos = (POS_W+2)'(acc_x_r) + (POS_W+2)'(rnd20);
    end else begin
      sum_pos = (POS_W+2)'(acc_y_r) + (POS_W+2)'(rnd20);
    end
    if (sum_pos > POS_MAX) begin
      sat_pos = POS_MAX[POS_W-1:0];
    end else if (sum_pos < POS_MIN) begin
      sat_pos = POS_MIN[POS_W-1:0];
    end else begin
      sat_pos = sum_pos[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x_r <= GAIN_RESET;
      gain_y_r <= GAIN_RESET;
      gain_tp_r <= GAIN_RESET;
      gain_tn_r <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_GAIN_X:        gain_x_r  <= cfg_wdata;
        CFG_GAIN_Y:        gain_y_r  <= cfg_wdata;
        CFG_GAIN_TURN_POS: gain_tp_r <= cfg_wdata;
        CFG_GAIN_TURN_NEG: gain_tn_r <= cfg_wdata;
        default:           gain_x_r  <= gain_x_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_h_r <= '0;
    end else begin
      if (cmd.wb_sel == WB_DX) begin
        acc_x_r <= sat_pos;
      end
      if (cmd.wb_sel == WB_DY) begin
        acc_y_r <= sat_pos;
        acc_h_r <= acc_h_r + h_r[T_W-1:28];
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= prod;
    if (cmd.load_in) begin
      vx_r  <= in_vel_x;
      vy_r  <= in_vel_y;
      vz_r  <= in_turn_rate;
      dt_r  <= in_time_step;
      neg_r <= in_ready_quad(acc_h_r);
      z_r   <= Z_W'(z_init);
    end
    unique case (cmd.wb_sel)
      WB_SX: sx_r <= sat_vel;
      WB_SY: sy_r <= sat_vel;
      WB_SZ: sz_r <= sat_vel;
      WB_X:  x_r  <= xr;
      WB_Y:  y_r  <= xr;
      WB_T:  t_r  <= p_r[T_W-1:0];
      WB_HL: h_r  <= T_W'(p_r[49:0]) + (T_W'(1) << 27);
      WB_HH: h_r  <= h_r + {p_r[29:0], 30'b0};
      default: ;
    endcase
    if (cmd.cordic_en) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_s;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_s;
      end
    end
    if (cmd.out_load) begin
      out_pos_x            <= acc_x_r;
      out_pos_y            <= acc_y_r;
      out_heading          <= acc_h_r;
      out_scaled_vel_x     <= sx_r;
      out_scaled_vel_y     <= sy_r;
      out_scaled_turn_rate <= sz_r;
      out_stationary       <= (sx_r == '0) && (sy_r == '0) && (sz_r == '0);
    end
  end

endmodule

// ===== hw/rtl/planar_odometry_integrator.sv =====
// channel | handshake              | payload
// in      | in_valid / in_ready    | vel_x, vel_y, turn_rate, time_step
// out     | out_valid / out_ready  | pos_x, pos_y, heading, scaled velocities, stationary
// cfg     | cfg_we                 | cfg_idx, cfg_wdata (gain registers)
//
// one item at a time: the next item is accepted only after the previous one is
// loaded into the output register, with the pace set by the shared 35x31 multiplier
// sequence and the iterative cordic rotation
// the result sits in an output register; the next item is taken while it waits,
// and its final load stalls only if the previous result is still not taken
// synchronous active-low reset clears pose and control state and sets the gains to GAIN_RESET
module planar_odometry_integrator
  import poi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [GAIN_W-1:0]       cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  logic signed [VEL_W-1:0] in_turn_rate,
  input  logic [DT_W-1:0]         in_time_step,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [HDG_W-1:0] out_heading,
  output logic signed [VEL_W-1:0] out_scaled_vel_x,
  output logic signed [VEL_W-1:0] out_scaled_vel_y,
  output logic signed [VEL_W-1:0] out_scaled_turn_rate,
  output logic                    out_stationary
);

  localparam int ITER_W = $clog2(CORDIC_STEPS);

  poi_cmd_t          cmd;
  logic [ITER_W-1:0] iter;

  poi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ITER_W(ITER_W)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd(cmd),
    .iter(iter)
  );

  poi_dp #(
    .ITER_W(ITER_W)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .iter(iter),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_vel_x(in_vel_x),
    .in_vel_y(in_vel_y),
    .in_turn_rate(in_turn_rate),
    .in_time_step(in_time_step),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_heading(out_heading),
    .out_scaled_vel_x(out_scaled_vel_x),
    .out_scaled_vel_y(out_scaled_vel_y),
    .out_scaled_turn_rate(out_scaled_turn_rate),
    .out_stationary(out_stationary)
  );

endmodule

// ===== hw/rtl/poi_checker.sv =====
module poi_checker
  import poi_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] out_pos_x,
  input logic signed [POS_W-1:0] out_pos_y,
  input logic signed [HDG_W-1:0] out_heading,
  input logic signed [VEL_W-1:0] out_scaled_vel_x,
  input logic signed [VEL_W-1:0] out_scaled_vel_y,
  input logic signed [VEL_W-1:0] out_scaled_turn_rate,
  input logic                    out_stationary
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pos_x) && $stable(out_pos_y) &&
      $stable(out_heading) && $stable(out_scaled_vel_x) &&
      $stable(out_scaled_vel_y) && $stable(out_scaled_turn_rate) &&
      $stable(out_stationary))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in work");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (.*);

// ===== tb/tb_planar_odometry_integrator.sv =====
module tb_planar_odometry_integrator;
  timeunit 1ns;
  timeprecision 1ps;
  import poi_pkg::*;

  localparam int  WATCHDOG_LIMIT = 5000;
  localparam longint POS_MAX = 64'sd140737488355327;
  localparam longint POS_MIN = -64'sd140737488355328;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [HDG_W-1:0] heading;
    logic signed [VEL_W-1:0] svx;
    logic signed [VEL_W-1:0] svy;
    logic signed [VEL_W-1:0] stz;
    logic                    stationary;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_GAIN_X;
  logic [GAIN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VEL_W-1:0] in_vel_x = '0, in_vel_y = '0, in_turn_rate = '0;
  logic [DT_W-1:0] in_time_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y;
  logic signed [HDG_W-1:0] out_heading;
  logic signed [VEL_W-1:0] out_scaled_vel_x, out_scaled_vel_y, out_scaled_turn_rate;
  logic out_stationary;

  always #6 clk = ~clk;

  planar_odometry_integrator dut (.*);

  function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rshift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  class odometry_scoreboard;
    logic [GAIN_W-1:0] gain [4];
    longint px, py;
    logic [31:0] hdg;
    pose_t pending[$];
    int errors;

    function void clear();
      foreach (gain[i]) gain[i] = GAIN_RESET;
      px = 0; py = 0; hdg = 0;
    endfunction

    function void set_gain(cfg_idx_t idx, logic [GAIN_W-1:0] v);
      gain[idx] = v;
    endfunction

    function longint scale(longint v, logic [GAIN_W-1:0] g);
      return clamp(rshift(v * longint'(g), 16), -64'sd2147483648, 64'sd2147483647);
    endfunction

    function void note_input(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, logic [DT_W-1:0] dt);
      longint sx, sy, sz, x, y, z, xs, ys, wx, wy;
      logic [31:0] h;
      logic [63:0] p;
      pose_t e;
      sx = scale(vx, gain[CFG_GAIN_X]);
      sy = scale(vy, gain[CFG_GAIN_Y]);
      sz = scale(vz, vz >= 0 ? gain[CFG_GAIN_TURN_POS] : gain[CFG_GAIN_TURN_NEG]);
      x = rshift(sx * longint'(INV_GAIN), 14);
      y = rshift(sy * longint'(INV_GAIN), 14);
      h = hdg;
      // second or third quadrant: flip vector, rotate angle by half a turn
      if (h[31] ^ h[30]) begin
        x = -x; y = -y; h = h + 32'h8000_0000;
      end
      z = longint'($signed(h));
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        xs = fshift(x, i);
        ys = fshift(y, i);
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(poi_atan(5'(i)));
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(poi_atan(5'(i)));
        end
      end
      wx = rshift(x, 16);
      wy = rshift(y, 16);
      px = clamp(px + rshift(wx * longint'(dt), 20), POS_MIN, POS_MAX);
      py = clamp(py + rshift(wy * longint'(dt), 20), POS_MIN, POS_MAX);
      p = 64'(sz) * 64'(TURN_K) * 64'(dt);
      p = (p + (64'd1 << 27)) >> 28;
      hdg = hdg + p[31:0];
      e.pos_x = px[POS_W-1:0];
      e.pos_y = py[POS_W-1:0];
      e.heading = hdg;
      e.svx = sx[31:0];
      e.svy = sy[31:0];
      e.stz = sz[31:0];
      e.stationary = (sx == 0 && sy == 0 && sz == 0);
      pending.push_back(e);
    endfunction

    function void check_result(pose_t a);
      pose_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pos_x=%0d", a.pos_x);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp x=%0d y=%0d h=%h sv=%0d/%0d/%0d st=%b",
                   e.pos_x, e.pos_y, e.heading, e.svx, e.svy, e.stz, e.stationary);
          $display("         got x=%0d y=%0d h=%h sv=%0d/%0d/%0d st=%b",
                   a.pos_x, a.pos_y, a.heading, a.svx, a.svy, a.stz, a.stationary);
        end
      end
    endfunction
  endclass

  odometry_scoreboard pose_sb = new();
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  // result side: check each taken result; random stalls, one long hold-off on request
  always @(posedge clk) begin
    pose_t a;
    if (rst_n && out_valid && out_ready) begin
      a.pos_x = out_pos_x; a.pos_y = out_pos_y; a.heading = out_heading;
      a.svx = out_scaled_vel_x; a.svy = out_scaled_vel_y; a.stz = out_scaled_turn_rate;
      a.stationary = out_stationary;
      pose_sb.check_result(a);
    end
  end

  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_planar_odometry_integrator failed");
      $finish;
    end
  end

  task automatic send_sample(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, logic [DT_W-1:0] dt, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 14) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vel_x <= vx; in_vel_y <= vy; in_turn_rate <= vz; in_time_step <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pose_sb.note_input(vx, vy, vz, dt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pose_sb.pending.size() != 0) @(posedge clk);
    repeat (CORDIC_STEPS_DEF + 20) @(posedge clk);
  endtask

  task automatic write_gain(cfg_idx_t idx, logic [GAIN_W-1:0] v);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pose_sb.set_gain(idx, v);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 20'hFFFFF;
      default: return DT_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [GAIN_W-1:0] gsets [4][4];
    gsets = '{'{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF},
              '{18'd0, 18'd0, 18'd0, 18'd0},
              '{18'd65536, 18'd32768, 18'd98304, 18'd1},
              '{18'd70000, 18'd60000, 18'd0, 18'h3FFFF}};
    pose_sb.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset gains, extremes, quadrants, zero step
    send_sample(0, 0, 0, 0, 0);
    send_sample(32'sh0001_0000, 0, 0, 20'hFFFFF, 0);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 20'hFFFFF, 0);
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 20'hFFFFF, 0);
    send_sample(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0);
    for (int q = 0; q < 8; q++)
      send_sample(32'sh0003_0000, -32'sh0001_0000, 32'sh0006_0000, 20'h40000, 1);
    for (int q = 0; q < 6; q++)
      send_sample(-32'sh0002_0000, 32'sh0001_8000, -32'sh0004_0000, 20'h80000, 1);
    drain();
    write_gain(CFG_GAIN_X, 18'h3FFFF);
    write_gain(CFG_GAIN_Y, 18'h3FFFF);
    send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh4000_0000, 20'hFFFFF, 0);
    // repeated max displacement on both axes
    for (int q = 0; q < 4; q++)
      send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 20'hFFFFF, 0);
    send_sample(32'sh8000_0000, 32'sh8000_0000, -32'sh1, 20'hFFFFF, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) begin
        write_gain(CFG_GAIN_X, gsets[ph][0]);
        write_gain(CFG_GAIN_Y, gsets[ph][1]);
        write_gain(CFG_GAIN_TURN_POS, gsets[ph][2]);
        write_gain(CFG_GAIN_TURN_NEG, gsets[ph][3]);
      end else begin
        for (int r = 0; r < 4; r++) write_gain(cfg_idx_t'(r), GAIN_W'($urandom()));
      end
      for (int n = 0; n < 175; n++) begin
        if (ph == 2 && n == 20) hold_off = 1'b1;
        send_sample(rand_vel(), rand_vel(), rand_vel(), rand_dt(),
                    !(n >= 60 && n < 90));
      end
      drain();
    end

    if (pose_sb.errors == 0 && pose_sb.pending.size() == 0)
      $display("tb_planar_odometry_integrator passed");
    else
      $display("tb_planar_odometry_integrator failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/poi_pkg.sv
hw/rtl/poi_ctrl.sv
hw/rtl/poi_dp.sv
hw/rtl/planar_odometry_integrator.sv
hw/rtl/poi_checker.sv
tb/tb_planar_odometry_integrator.sv
